/* rtl/core/ps2kd_pkg.sv */
// ps2kd_pkg: shared types, constants and lookup tables of the scan code set 2 decoder
// holds the parse phase enum, the event word type, the scan code maps and the
// default symbol layout; depends on nothing
package ps2kd_pkg;

   // widths
   localparam int BYTE_W       = 8;
   localparam int SCAN_DEPTH   = 6;
   localparam int SCAN_CNT_W   = 3;
   localparam int MOD_COUNT    = 8;

   // symbol memory: layers 0 and 1 only, layers 2 and 3 read as zero
   localparam int SYM_WIDTH    = 9;
   localparam int SYM_DEPTH    = 512;
   localparam int SYM_ADDR_W   = $clog2(SYM_DEPTH);

   // received byte codes
   localparam logic [7:0] BYTE_EXT     = 8'hE0;
   localparam logic [7:0] BYTE_BREAK   = 8'hF0;
   localparam logic [7:0] BYTE_PRT_REL = 8'h7C;
   localparam logic [7:0] BYTE_PRT_MK  = 8'h12;
   localparam logic [7:0] BYTE_PP_MK   = 8'h2A;
   localparam logic [7:0] BYTE_PP_END  = 8'h37;

   // map bounds
   localparam logic [7:0] PLAIN_LIMIT  = 8'd132;
   localparam logic [7:0] EXT_LIMIT    = 8'd128;

   // special key codes
   localparam logic [7:0] KC_NONE      = 8'hE0;
   localparam logic [7:0] KC_UNSUP     = 8'hE1;
   localparam logic [7:0] KC_UNKNOWN   = 8'hE2;
   localparam logic [7:0] KC_PRTSC     = 8'h0D;
   localparam logic [7:0] KC_PAUSE     = 8'h11;
   localparam logic [7:0] KC_CAPS      = 8'h60;   // row 3 col 0
   localparam logic [7:0] KC_NUM       = 8'h2E;   // row 1 col 14

   // modifier keys in mask bit order
   localparam logic [MOD_COUNT-1:0][7:0] MOD_KEYS = {
      8'hA7, 8'hA5, 8'hA8, 8'h8C, 8'hA2, 8'hA3, 8'hA0, 8'h80
   };

   typedef enum logic [3:0] {
      PH_IDLE = 4'd0,
      PH_E0   = 4'd1,
      PH_F0   = 4'd2,
      PH_E0F0 = 4'd3,
      PH_PSR1 = 4'd4,
      PH_PSR2 = 4'd5,
      PH_PSR3 = 4'd6,
      PH_PM1  = 4'd7,
      PH_PM2  = 4'd8,
      PH_PP1  = 4'd9,
      PH_PP2  = 4'd10
   } phase_type;

   // one decoded event on its way to the output
   typedef struct packed {
      logic [7:0]                   key_code;
      logic                         pressed;
      logic [7:0]                   modifiers;
      logic                         caps;
      logic                         num;
      logic                         zero_sym;
      logic [SCAN_DEPTH-1:0][7:0]   scan;
   } event_type;

   function automatic logic [7:0] kc_of(input logic [2:0] row, input logic [4:0] col);
      return {row, col};
   endfunction

   // plain scan code to row/column key code
   function automatic logic [7:0] plain_map(input logic [7:0] b);
      logic [7:0] m;
      case (b)
         8'h01: m = kc_of(3'd0, 5'd9);
         8'h03: m = kc_of(3'd0, 5'd5);
         8'h04: m = kc_of(3'd0, 5'd3);
         8'h05: m = kc_of(3'd0, 5'd1);
         8'h06: m = kc_of(3'd0, 5'd2);
         8'h07: m = kc_of(3'd0, 5'd12);
         8'h09: m = kc_of(3'd0, 5'd10);
         8'h0A: m = kc_of(3'd0, 5'd8);
         8'h0B: m = kc_of(3'd0, 5'd6);
         8'h0C: m = kc_of(3'd0, 5'd4);
         8'h0D: m = kc_of(3'd2, 5'd0);
         8'h0E: m = kc_of(3'd1, 5'd13);
         8'h11: m = kc_of(3'd5, 5'd3);
         8'h12: m = kc_of(3'd4, 5'd0);
         8'h14: m = kc_of(3'd5, 5'd0);
         8'h15: m = kc_of(3'd2, 5'd1);
         8'h16: m = kc_of(3'd1, 5'd1);
         8'h1A: m = kc_of(3'd4, 5'd2);
         8'h1B: m = kc_of(3'd3, 5'd2);
         8'h1C: m = kc_of(3'd3, 5'd1);
         8'h1D: m = kc_of(3'd2, 5'd2);
         8'h1E: m = kc_of(3'd1, 5'd2);
         8'h21: m = kc_of(3'd4, 5'd4);
         8'h22: m = kc_of(3'd4, 5'd3);
         8'h23: m = kc_of(3'd3, 5'd3);
         8'h24: m = kc_of(3'd2, 5'd3);
         8'h25: m = kc_of(3'd1, 5'd4);
         8'h26: m = kc_of(3'd1, 5'd3);
         8'h29: m = kc_of(3'd5, 5'd4);
         8'h2A: m = kc_of(3'd4, 5'd5);
         8'h2B: m = kc_of(3'd3, 5'd4);
         8'h2C: m = kc_of(3'd2, 5'd5);
         8'h2D: m = kc_of(3'd2, 5'd4);
         8'h2E: m = kc_of(3'd1, 5'd5);
         8'h31: m = kc_of(3'd4, 5'd7);
         8'h32: m = kc_of(3'd4, 5'd6);
         8'h33: m = kc_of(3'd3, 5'd6);
         8'h34: m = kc_of(3'd3, 5'd5);
         8'h35: m = kc_of(3'd2, 5'd6);
         8'h36: m = kc_of(3'd1, 5'd6);
         8'h3A: m = kc_of(3'd4, 5'd8);
         8'h3B: m = kc_of(3'd3, 5'd7);
         8'h3C: m = kc_of(3'd2, 5'd7);
         8'h3D: m = kc_of(3'd1, 5'd7);
         8'h3E: m = kc_of(3'd1, 5'd8);
         8'h41: m = kc_of(3'd4, 5'd9);
         8'h42: m = kc_of(3'd3, 5'd8);
         8'h43: m = kc_of(3'd2, 5'd8);
         8'h44: m = kc_of(3'd2, 5'd9);
         8'h45: m = kc_of(3'd1, 5'd10);
         8'h46: m = kc_of(3'd1, 5'd9);
         8'h49: m = kc_of(3'd4, 5'd10);
         8'h4A: m = kc_of(3'd4, 5'd11);
         8'h4B: m = kc_of(3'd3, 5'd9);
         8'h4C: m = kc_of(3'd3, 5'd10);
         8'h4D: m = kc_of(3'd2, 5'd10);
         8'h4E: m = kc_of(3'd1, 5'd11);
         8'h52: m = kc_of(3'd3, 5'd11);
         8'h54: m = kc_of(3'd2, 5'd11);
         8'h55: m = kc_of(3'd1, 5'd12);
         8'h58: m = kc_of(3'd3, 5'd0);
         8'h59: m = kc_of(3'd4, 5'd12);
         8'h5A: m = kc_of(3'd2, 5'd13);
         8'h5B: m = kc_of(3'd2, 5'd12);
         8'h5D: m = kc_of(3'd3, 5'd12);
         8'h61: m = kc_of(3'd4, 5'd1);
         8'h66: m = kc_of(3'd1, 5'd13);
         8'h69: m = kc_of(3'd4, 5'd14);
         8'h6B: m = kc_of(3'd3, 5'd14);
         8'h6C: m = kc_of(3'd2, 5'd14);
         8'h70: m = kc_of(3'd5, 5'd12);
         8'h71: m = kc_of(3'd5, 5'd13);
         8'h72: m = kc_of(3'd4, 5'd15);
         8'h73: m = kc_of(3'd3, 5'd15);
         8'h74: m = kc_of(3'd3, 5'd16);
         8'h75: m = kc_of(3'd2, 5'd15);
         8'h76: m = kc_of(3'd0, 5'd0);
         8'h77: m = kc_of(3'd1, 5'd14);
         8'h78: m = kc_of(3'd0, 5'd11);
         8'h79: m = kc_of(3'd2, 5'd17);
         8'h7A: m = kc_of(3'd4, 5'd16);
         8'h7B: m = kc_of(3'd1, 5'd17);
         8'h7C: m = kc_of(3'd1, 5'd16);
         8'h7D: m = kc_of(3'd2, 5'd16);
         8'h7E: m = kc_of(3'd7, 5'd1);
         8'h83: m = kc_of(3'd0, 5'd7);
         default: m = KC_NONE;
      endcase
      return m;
   endfunction

   // extended (E0-prefixed) scan code to key code
   function automatic logic [7:0] ext_map(input logic [7:0] b);
      logic [7:0] m;
      case (b)
         8'h10, 8'h15, 8'h18, 8'h20, 8'h21, 8'h23, 8'h28, 8'h2B, 8'h2F,
         8'h30, 8'h32, 8'h34, 8'h37, 8'h38, 8'h3A, 8'h3B, 8'h3F, 8'h40,
         8'h48, 8'h4D, 8'h50, 8'h5E: m = KC_UNSUP;
         8'h11: m = kc_of(3'd5, 5'd5);
         8'h14: m = kc_of(3'd5, 5'd8);
         8'h1F: m = kc_of(3'd5, 5'd2);
         8'h27: m = kc_of(3'd5, 5'd7);
         8'h4A: m = kc_of(3'd1, 5'd15);
         8'h5A: m = kc_of(3'd4, 5'd17);
         8'h69: m = kc_of(3'd0, 5'd17);
         8'h6B: m = kc_of(3'd5, 5'd9);
         8'h6C: m = kc_of(3'd0, 5'd16);
         8'h70: m = kc_of(3'd0, 5'd14);
         8'h71: m = kc_of(3'd0, 5'd15);
         8'h72: m = kc_of(3'd5, 5'd10);
         8'h74: m = kc_of(3'd5, 5'd11);
         8'h75: m = kc_of(3'd4, 5'd13);
         8'h7A: m = kc_of(3'd0, 5'd19);
         8'h7D: m = kc_of(3'd0, 5'd18);
         default: m = KC_NONE;
      endcase
      return m;
   endfunction

   // default US layout; bit 8 marks a numpad entry
   function automatic logic [8:0] sym_default(input logic shift, input logic [7:0] kc);
      logic [8:0] s;
      case (kc)
         kc_of(3'd1, 5'd1):  s = shift ? 9'h021 : 9'h031;
         kc_of(3'd1, 5'd2):  s = shift ? 9'h040 : 9'h032;
         kc_of(3'd1, 5'd3):  s = shift ? 9'h023 : 9'h033;
         kc_of(3'd1, 5'd4):  s = shift ? 9'h024 : 9'h034;
         kc_of(3'd1, 5'd5):  s = shift ? 9'h025 : 9'h035;
         kc_of(3'd1, 5'd6):  s = shift ? 9'h05E : 9'h036;
         kc_of(3'd1, 5'd7):  s = shift ? 9'h026 : 9'h037;
         kc_of(3'd1, 5'd8):  s = shift ? 9'h02A : 9'h038;
         kc_of(3'd1, 5'd9):  s = shift ? 9'h028 : 9'h039;
         kc_of(3'd1, 5'd10): s = shift ? 9'h029 : 9'h030;
         kc_of(3'd1, 5'd11): s = shift ? 9'h05F : 9'h02D;
         kc_of(3'd1, 5'd12): s = shift ? 9'h02B : 9'h03D;
         kc_of(3'd1, 5'd13): s = 9'h008;
         kc_of(3'd1, 5'd15): s = 9'h02F;
         kc_of(3'd1, 5'd16): s = 9'h02A;
         kc_of(3'd1, 5'd17): s = 9'h02D;
         kc_of(3'd2, 5'd1):  s = shift ? 9'h051 : 9'h071;
         kc_of(3'd2, 5'd2):  s = shift ? 9'h057 : 9'h077;
         kc_of(3'd2, 5'd3):  s = shift ? 9'h045 : 9'h065;
         kc_of(3'd2, 5'd4):  s = shift ? 9'h052 : 9'h072;
         kc_of(3'd2, 5'd5):  s = shift ? 9'h054 : 9'h074;
         kc_of(3'd2, 5'd6):  s = shift ? 9'h059 : 9'h079;
         kc_of(3'd2, 5'd7):  s = shift ? 9'h055 : 9'h075;
         kc_of(3'd2, 5'd8):  s = shift ? 9'h049 : 9'h069;
         kc_of(3'd2, 5'd9):  s = shift ? 9'h04F : 9'h06F;
         kc_of(3'd2, 5'd10): s = shift ? 9'h050 : 9'h070;
         kc_of(3'd2, 5'd11): s = shift ? 9'h07B : 9'h05B;
         kc_of(3'd2, 5'd12): s = shift ? 9'h07D : 9'h05D;
         kc_of(3'd2, 5'd13): s = 9'h00A;
         kc_of(3'd2, 5'd14): s = 9'h137;
         kc_of(3'd2, 5'd15): s = 9'h138;
         kc_of(3'd2, 5'd16): s = 9'h139;
         kc_of(3'd2, 5'd17): s = 9'h02B;
         kc_of(3'd3, 5'd1):  s = shift ? 9'h041 : 9'h061;
         kc_of(3'd3, 5'd2):  s = shift ? 9'h053 : 9'h073;
         kc_of(3'd3, 5'd3):  s = shift ? 9'h044 : 9'h064;
         kc_of(3'd3, 5'd4):  s = shift ? 9'h046 : 9'h066;
         kc_of(3'd3, 5'd5):  s = shift ? 9'h047 : 9'h067;
         kc_of(3'd3, 5'd6):  s = shift ? 9'h048 : 9'h068;
         kc_of(3'd3, 5'd7):  s = shift ? 9'h04A : 9'h06A;
         kc_of(3'd3, 5'd8):  s = shift ? 9'h04B : 9'h06B;
         kc_of(3'd3, 5'd9):  s = shift ? 9'h04C : 9'h06C;
         kc_of(3'd3, 5'd10): s = shift ? 9'h03A : 9'h03B;
         kc_of(3'd3, 5'd11): s = shift ? 9'h022 : 9'h027;
         kc_of(3'd3, 5'd12): s = shift ? 9'h07C : 9'h05C;
         kc_of(3'd3, 5'd14): s = 9'h134;
         kc_of(3'd3, 5'd15): s = 9'h135;
         kc_of(3'd3, 5'd16): s = 9'h136;
         kc_of(3'd4, 5'd2):  s = shift ? 9'h05A : 9'h07A;
         kc_of(3'd4, 5'd3):  s = shift ? 9'h058 : 9'h078;
         kc_of(3'd4, 5'd4):  s = shift ? 9'h043 : 9'h063;
         kc_of(3'd4, 5'd5):  s = shift ? 9'h056 : 9'h076;
         kc_of(3'd4, 5'd6):  s = shift ? 9'h042 : 9'h062;
         kc_of(3'd4, 5'd7):  s = shift ? 9'h04E : 9'h06E;
         kc_of(3'd4, 5'd8):  s = shift ? 9'h04D : 9'h06D;
         kc_of(3'd4, 5'd9):  s = shift ? 9'h03C : 9'h02C;
         kc_of(3'd4, 5'd10): s = shift ? 9'h03E : 9'h02E;
         kc_of(3'd4, 5'd11): s = shift ? 9'h03F : 9'h02F;
         kc_of(3'd4, 5'd14): s = 9'h131;
         kc_of(3'd4, 5'd15): s = 9'h132;
         kc_of(3'd4, 5'd16): s = 9'h133;
         kc_of(3'd4, 5'd17): s = 9'h00A;
         kc_of(3'd5, 5'd4):  s = 9'h020;
         kc_of(3'd5, 5'd12): s = 9'h030;
         default:            s = 9'h000;
      endcase
      return s;
   endfunction

endpackage

/* rtl/core/ps2kd_ram.sv */
// ps2kd_ram: generic single-port-write, single-port-read ram with registered read
// width and depth set by parameters; depends on nothing
module ps2kd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ps2_set2_key_event_decoder_core.sv */
// ps2_set2_key_event_decoder_core: scan code set 2 parser and key event generator
// depends on ps2kd_pkg (tables, types) and ps2kd_ram (symbol memory)
//
// usage
//  req channel: one received keyboard byte per word (req_rx_byte).
//  rsp channel: one event word per completed scan code sequence: key code,
//    make/break, modifier mask as it stood before the event, keymap symbol,
//    lock states after the event and up to six captured bytes, zero-filled.
//  bytes that only extend a sequence (E0, F0, multi-byte print screen and
//    pause forms) produce no rsp word.
//  path: the event word passes the parse stage, then the symbol memory read
//    stage, into the output register before it shows on rsp.
//  throughput: one byte per cycle while req_stall is low; req_stall rises
//    during the memory load and while an event in the memory read stage
//    cannot move, and then holds every byte, also one that ends no sequence.
//  reset: sequence state, lock states and the modifier state clear at once;
//    then the symbol memory is loaded with the default layout, one entry a
//    cycle, over all 512 entries, during which req_stall stays high.
//  rsp_stall: the output word holds; one more event can wait in the memory
//    read stage, after which req_stall rises until the receiver takes a word.
module ps2_set2_key_event_decoder_core
   import ps2kd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_key_code,
   output logic       rsp_pressed,
   output logic [7:0] rsp_modifiers,
   output logic [7:0] rsp_key_symbol,
   output logic       rsp_caps_status,
   output logic       rsp_num_status,
   output logic [7:0] rsp_scan_byte_a,
   output logic [7:0] rsp_scan_byte_b,
   output logic [7:0] rsp_scan_byte_c,
   output logic [7:0] rsp_scan_byte_d,
   output logic [7:0] rsp_scan_byte_e,
   output logic [7:0] rsp_scan_byte_f
);

   // sequence state
   phase_type                     phase_ff, phase_in;
   logic                          release_ff, release_in;
   logic [SCAN_DEPTH-1:0][7:0]    scan_ff, scan_in;
   logic [SCAN_CNT_W-1:0]         scan_cnt_ff, scan_cnt_in;

   // key state: modifier entries of the key-down map and lock states
   logic [MOD_COUNT-1:0]          mods_ff, mods_in;
   logic                          caps_ff, caps_in;
   logic                          num_ff, num_in;

   // symbol memory load after reset
   logic                          init_busy_ff, init_busy_in;
   logic [SYM_ADDR_W-1:0]         init_addr_ff, init_addr_in;

   // memory read stage and output register
   logic                          s1_valid_ff, s1_valid_in;
   event_type                     s1_ff, s1_in;
   logic                          out_valid_ff, out_valid_in;
   event_type                     out_ff, out_in;
   logic [7:0]                    out_sym_ff, out_sym_in;

   // parse stage signals
   logic                          accept;
   logic                          s1_move;
   logic [SCAN_DEPTH-1:0][7:0]    scan_seq;
   logic [SCAN_CNT_W-1:0]         scan_cnt_seq;
   phase_type                     ext_phase;
   logic                          ext_emit;
   logic [7:0]                    ext_kc;
   logic [7:0]                    plain_kc;
   phase_type                     parse_phase;
   logic                          parse_release;
   logic                          parse_emit;
   logic [7:0]                    parse_kc;
   logic                          press;
   logic                          caps_new;
   logic                          num_new;
   event_type                     ev;

   // memory ports
   logic                          ram_wr_en;
   logic [SYM_ADDR_W-1:0]         ram_wr_addr;
   logic [SYM_WIDTH-1:0]          ram_wr_data;
   logic                          ram_rd_en;
   logic [SYM_ADDR_W-1:0]         ram_rd_addr;
   logic [SYM_WIDTH-1:0]          ram_rd_data;

   // handshake
   assign s1_move   = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = init_busy_ff || (s1_valid_ff && !s1_move);
   assign accept    = req_valid && !req_stall;

   // byte capture, first six bytes of a sequence
   always_comb begin
      scan_seq     = scan_ff;
      scan_cnt_seq = scan_cnt_ff;
      if (scan_cnt_ff < SCAN_CNT_W'(SCAN_DEPTH)) begin
         scan_seq[scan_cnt_ff] = req_rx_byte;
         scan_cnt_seq          = scan_cnt_ff + 1'b1;
      end
   end

   // plain and extended code lookup
   assign plain_kc = (req_rx_byte < PLAIN_LIMIT) ? plain_map(req_rx_byte) : KC_UNKNOWN;

   always_comb begin
      ext_phase = PH_IDLE;
      ext_emit  = 1'b0;
      ext_kc    = KC_UNKNOWN;
      if (release_ff && req_rx_byte == BYTE_PRT_REL) begin
         ext_phase = PH_PSR1;
      end else if (req_rx_byte == BYTE_PRT_MK) begin
         ext_phase = PH_PM1;
      end else if (req_rx_byte == BYTE_PP_MK) begin
         ext_phase = PH_PP1;
      end else begin
         ext_emit = 1'b1;
         ext_kc   = (req_rx_byte < EXT_LIMIT) ? ext_map(req_rx_byte) : KC_UNKNOWN;
      end
   end

   // phase transition for the received byte
   always_comb begin
      parse_phase   = PH_IDLE;
      parse_release = release_ff;
      parse_emit    = 1'b1;
      parse_kc      = KC_UNKNOWN;
      case (phase_ff)
         PH_E0: begin
            if (req_rx_byte == BYTE_BREAK) begin
               parse_release = 1'b1;
               parse_phase   = PH_E0F0;
               parse_emit    = 1'b0;
            end else begin
               parse_phase = ext_phase;
               parse_emit  = ext_emit;
               parse_kc    = ext_kc;
            end
         end
         PH_F0: begin
            parse_kc = plain_kc;
         end
         PH_E0F0: begin
            parse_phase = ext_phase;
            parse_emit  = ext_emit;
            parse_kc    = ext_kc;
         end
         PH_PSR1: begin
            if (req_rx_byte == BYTE_EXT) begin
               parse_phase = PH_PSR2;
               parse_emit  = 1'b0;
            end
         end
         PH_PSR2: begin
            if (req_rx_byte == BYTE_BREAK) begin
               parse_phase = PH_PSR3;
               parse_emit  = 1'b0;
            end
         end
         PH_PSR3: begin
            parse_kc = (req_rx_byte == BYTE_PRT_MK) ? KC_PRTSC : KC_UNKNOWN;
         end
         PH_PM1: begin
            if (req_rx_byte == BYTE_EXT) begin
               parse_phase = PH_PM2;
               parse_emit  = 1'b0;
            end
         end
         PH_PM2: begin
            parse_kc = (req_rx_byte == BYTE_PRT_REL) ? KC_PRTSC : KC_UNKNOWN;
         end
         PH_PP1: begin
            if (req_rx_byte == BYTE_EXT) begin
               parse_phase = PH_PP2;
               parse_emit  = 1'b0;
            end
         end
         PH_PP2: begin
            parse_kc = (req_rx_byte == BYTE_PP_END) ? KC_PAUSE : KC_UNKNOWN;
         end
         default: begin
            if (req_rx_byte == BYTE_EXT) begin
               parse_phase = PH_E0;
               parse_emit  = 1'b0;
            end else if (req_rx_byte == BYTE_BREAK) begin
               parse_release = 1'b1;
               parse_phase   = PH_F0;
               parse_emit    = 1'b0;
            end else begin
               parse_kc = plain_kc;
            end
         end
      endcase
   end

   // event fields: lock toggles on press, modifiers taken before the update
   assign press    = !release_ff;
   assign caps_new = caps_ff ^ (press && parse_kc == KC_CAPS);
   assign num_new  = num_ff ^ (press && parse_kc == KC_NUM);

   always_comb begin
      ev.key_code  = parse_kc;
      ev.pressed   = press;
      ev.modifiers = mods_ff;
      ev.caps      = caps_new;
      ev.num       = num_new;
      ev.zero_sym  = mods_ff[6];
      ev.scan      = scan_seq;
   end

   // sequence and key state next values
   always_comb begin
      phase_in    = phase_ff;
      release_in  = release_ff;
      scan_in     = scan_ff;
      scan_cnt_in = scan_cnt_ff;
      mods_in     = mods_ff;
      caps_in     = caps_ff;
      num_in      = num_ff;
      if (accept) begin
         if (parse_emit) begin
            phase_in    = PH_IDLE;
            release_in  = 1'b0;
            scan_in     = '0;
            scan_cnt_in = '0;
            caps_in     = caps_new;
            num_in      = num_new;
            for (int i = 0; i < MOD_COUNT; i++) begin
               if (parse_kc == MOD_KEYS[i]) begin
                  mods_in[i] = press;
               end
            end
         end else begin
            phase_in    = parse_phase;
            release_in  = parse_release;
            scan_in     = scan_seq;
            scan_cnt_in = scan_cnt_seq;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_IDLE;
         release_ff  <= 1'b0;
         scan_ff     <= '0;
         scan_cnt_ff <= '0;
         mods_ff     <= '0;
         caps_ff     <= 1'b0;
         num_ff      <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         release_ff  <= release_in;
         scan_ff     <= scan_in;
         scan_cnt_ff <= scan_cnt_in;
         mods_ff     <= mods_in;
         caps_ff     <= caps_in;
         num_ff      <= num_in;
      end
   end

   // symbol memory load sweep
   always_comb begin
      init_busy_in = init_busy_ff;
      init_addr_in = init_addr_ff;
      if (init_busy_ff) begin
         init_addr_in = init_addr_ff + 1'b1;
         if (init_addr_ff == SYM_ADDR_W'(SYM_DEPTH - 1)) begin
            init_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         init_busy_ff <= 1'b1;
         init_addr_ff <= '0;
      end else begin
         init_busy_ff <= init_busy_in;
         init_addr_ff <= init_addr_in;
      end
   end

   assign ram_wr_en   = init_busy_ff;
   assign ram_wr_addr = init_addr_ff;
   assign ram_wr_data = sym_default(init_addr_ff[SYM_ADDR_W-1], init_addr_ff[BYTE_W-1:0]);

   // layer select: left shift xor caps picks the layer, right alt reads as the empty layers
   assign ram_rd_en   = accept && parse_emit;
   assign ram_rd_addr = {mods_ff[0] ^ caps_new, parse_kc};

   ps2kd_ram #(
      .WIDTH (SYM_WIDTH),
      .DEPTH (SYM_DEPTH)
   ) u_sym_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // memory read stage
   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_in       = s1_ff;
      if (ram_rd_en) begin
         s1_valid_in = 1'b1;
         s1_in       = ev;
      end else if (s1_move) begin
         s1_valid_in = 1'b0;
      end
   end

   // output register, symbol blanked for empty layers and numpad with num lock off
   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      out_sym_in   = out_sym_ff;
      if (s1_move) begin
         out_valid_in = 1'b1;
         out_in       = s1_ff;
         if (s1_ff.zero_sym || (ram_rd_data[SYM_WIDTH-1] && !s1_ff.num)) begin
            out_sym_in = '0;
         end else begin
            out_sym_in = ram_rd_data[BYTE_W-1:0];
         end
      end else if (out_valid_ff && !rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_ff      <= s1_in;
      out_ff     <= out_in;
      out_sym_ff <= out_sym_in;
   end

   // result word
   assign rsp_valid       = out_valid_ff;
   assign rsp_key_code    = out_ff.key_code;
   assign rsp_pressed     = out_ff.pressed;
   assign rsp_modifiers   = out_ff.modifiers;
   assign rsp_key_symbol  = out_sym_ff;
   assign rsp_caps_status = out_ff.caps;
   assign rsp_num_status  = out_ff.num;
   assign rsp_scan_byte_a = out_ff.scan[0];
   assign rsp_scan_byte_b = out_ff.scan[1];
   assign rsp_scan_byte_c = out_ff.scan[2];
   assign rsp_scan_byte_d = out_ff.scan[3];
   assign rsp_scan_byte_e = out_ff.scan[4];
   assign rsp_scan_byte_f = out_ff.scan[5];

endmodule

/* rtl/core/ps2kd_checker.sv */
// ps2kd_checker: port-level checks for the scan code set 2 decoder, bound to the top level
// depends on ps2kd_pkg (key and byte codes) and ps2_set2_key_event_decoder_core
module ps2kd_checker
   import ps2kd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [7:0] rsp_key_code,
   input logic       rsp_pressed,
   input logic [7:0] rsp_modifiers,
   input logic [7:0] rsp_key_symbol,
   input logic [7:0] rsp_scan_byte_a,
   input logic [7:0] rsp_scan_byte_b
);

   // a stalled result word stays and holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_key_code)
         && $stable(rsp_key_symbol) && $stable(rsp_modifiers) && $stable(rsp_scan_byte_a))
      else $error("stalled rsp word changed");

   // right after reset no word is shown and no byte is taken while the memory loads
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_stall)
      else $error("activity right after reset");

   // a break event always started with a prefix byte
   a_break_prefix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_pressed |-> rsp_scan_byte_a == BYTE_BREAK
         || rsp_scan_byte_a == BYTE_EXT)
      else $error("break word without prefix");

   // print screen only comes from an extended sequence
   a_prtsc_ext: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_key_code == KC_PRTSC && rsp_scan_byte_b != 8'h00
         |-> rsp_scan_byte_a == BYTE_EXT)
      else $error("print screen word without extended prefix");

   // the no-key, unsupported and unknown codes carry no symbol
   a_special_nosym: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_key_code == KC_NONE || rsp_key_code == KC_UNSUP
         || rsp_key_code == KC_UNKNOWN) |-> rsp_key_symbol == 8'h00)
      else $error("symbol on a special key code");

endmodule

bind ps2_set2_key_event_decoder_core ps2kd_checker u_ps2kd_checker (.*);
